### hw/rtl/bva_pkg.sv
// Shared types and constants for the bitvector ALU.
// No dependencies; every other file imports this package.
package bva_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int CMD_W     = 5;
	localparam int OPND_W    = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD  = 5'd0,
		CMD_SUB  = 5'd1,
		CMD_NEG  = 5'd2,
		CMD_MUL  = 5'd3,
		CMD_UDIV = 5'd4,
		CMD_SDIV = 5'd5,
		CMD_UREM = 5'd6,
		CMD_SREM = 5'd7,
		CMD_SMOD = 5'd8,
		CMD_SHL  = 5'd9,
		CMD_LSHR = 5'd10,
		CMD_ASHR = 5'd11,
		CMD_XOR  = 5'd12,
		CMD_AND  = 5'd13,
		CMD_OR   = 5'd14,
		CMD_NOT  = 5'd15,
		CMD_ULT  = 5'd16,
		CMD_ULE  = 5'd17,
		CMD_UGT  = 5'd18,
		CMD_UGE  = 5'd19,
		CMD_SLT  = 5'd20,
		CMD_SLE  = 5'd21,
		CMD_SGT  = 5'd22,
		CMD_SGE  = 5'd23
	} cmd_t;

	// control that travels with each beat down the chain
	typedef struct packed {
		logic valid;
		cmd_t cmd;
		logic neg_a;
		logic neg_b;
	} ctl_t;

endpackage

### hw/rtl/bva_if.sv
// Request and response channel interfaces for the bitvector ALU.
// Depends on bva_pkg for payload widths.
interface bva_req_if import bva_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [OPND_W-1:0] operand_a;
	logic [OPND_W-1:0] operand_b;

	modport source (output valid, command, operand_a, operand_b, input ready);
	modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface bva_rsp_if import bva_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OPND_W-1:0] result_value;
	logic              compare_true;

	modport source (output valid, result_value, compare_true, input ready);
	modport sink   (input valid, result_value, compare_true, output ready);
endinterface

### hw/rtl/bitvector_alu_smtlib.sv
// Top level of the bitvector ALU: front stage, chain of WIDTH cells, back.
// Depends on bva_pkg, bva_if, bva_front, bva_cell and bva_back.
//
//  channel  dir  payload                                   handshake
//  req      in   command[4:0] operand_a[31:0] operand_b    valid/ready
//  rsp      out  result_value[31:0] compare_true           valid/ready
//
// All commands share one path; one beat enters per cycle unless rsp stalls.
// The chain holds one cell per quotient/multiplier bit, so depth is WIDTH.
// Reset clears the control word of each stage; data registers are not reset.
// A stalled response freezes the whole chain; req.ready drops with it.
module bitvector_alu_smtlib import bva_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	bva_req_if.sink      req,
	bva_rsp_if.source    rsp
);

	logic             en;
	ctl_t             ctl_c    [WIDTH+1];
	logic [WIDTH-1:0] x_c      [WIDTH+1];
	logic [WIDTH-1:0] y_c      [WIDTH+1];
	logic [WIDTH-1:0] r_c      [WIDTH+1];
	logic [WIDTH-1:0] simple_c [WIDTH+1];
	logic             flag_c   [WIDTH+1];

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	bva_front #(.WIDTH(WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (req.valid),
		.command   (req.command),
		.a         (WIDTH'(req.operand_a)),
		.b         (WIDTH'(req.operand_b)),
		.ctl_s1    (ctl_c[0]),
		.x_s1      (x_c[0]),
		.y_s1      (y_c[0]),
		.r_s1      (r_c[0]),
		.simple_s1 (simple_c[0]),
		.flag_s1   (flag_c[0])
	);

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		bva_cell #(.WIDTH(WIDTH)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_i    (ctl_c[i]),
			.x_i      (x_c[i]),
			.y_i      (y_c[i]),
			.r_i      (r_c[i]),
			.simple_i (simple_c[i]),
			.flag_i   (flag_c[i]),
			.ctl_q    (ctl_c[i+1]),
			.x_q      (x_c[i+1]),
			.y_q      (y_c[i+1]),
			.r_q      (r_c[i+1]),
			.simple_q (simple_c[i+1]),
			.flag_q   (flag_c[i+1])
		);
	end

	bva_back #(.WIDTH(WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_i    (ctl_c[WIDTH]),
		.x_i      (x_c[WIDTH]),
		.y_i      (y_c[WIDTH]),
		.r_i      (r_c[WIDTH]),
		.simple_i (simple_c[WIDTH]),
		.flag_i   (flag_c[WIDTH]),
		.valid_q  (rsp.valid),
		.value_q  (rsp.result_value),
		.flag_q   (rsp.compare_true)
	);

`ifndef SYNTHESIS
	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request taken while response stalled");

	a_flag_only_compare: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.compare_true) |-> (rsp.result_value == '0))
		else $error("compare flag with nonzero value");

	a_chain_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(en && ctl_c[WIDTH].valid) |=> rsp.valid)
		else $error("beat lost at end of chain");
`endif

endmodule

### hw/rtl/bva_front.sv
// Input stage: decodes the command, computes the non-chain results and
// loads the operands for the multiply/divide chain. Depends on bva_pkg.
module bva_front import bva_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid,
	input  logic [CMD_W-1:0] command,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output ctl_t             ctl_s1,
	output logic [WIDTH-1:0] x_s1,
	output logic [WIDTH-1:0] y_s1,
	output logic [WIDTH-1:0] r_s1,
	output logic [WIDTH-1:0] simple_s1,
	output logic             flag_s1
);

	cmd_t             cmd;
	logic             sa, sb, is_signed;
	logic [WIDTH-1:0] abs_a, abs_b, simple, x_n, y_n;
	logic             flag;

	always_comb begin
		cmd       = cmd_t'(command);
		sa        = a[WIDTH-1];
		sb        = b[WIDTH-1];
		abs_a     = sa ? -a : a;
		abs_b     = sb ? -b : b;
		is_signed = (cmd == CMD_SDIV) || (cmd == CMD_SREM) || (cmd == CMD_SMOD);
		simple    = '0;
		flag      = 1'b0;
		case (cmd)
			CMD_ADD:  simple = a + b;
			CMD_SUB:  simple = a - b;
			CMD_NEG:  simple = -a;
			CMD_SHL:  simple = a << b;
			CMD_LSHR: simple = a >> b;
			CMD_ASHR: simple = WIDTH'($signed(a) >>> b);
			CMD_XOR:  simple = a ^ b;
			CMD_AND:  simple = a & b;
			CMD_OR:   simple = a | b;
			CMD_NOT:  simple = ~a;
			CMD_ULT:  flag = a < b;
			CMD_ULE:  flag = a <= b;
			CMD_UGT:  flag = a > b;
			CMD_UGE:  flag = a >= b;
			CMD_SLT:  flag = $signed(a) < $signed(b);
			CMD_SLE:  flag = $signed(a) <= $signed(b);
			CMD_SGT:  flag = $signed(a) > $signed(b);
			CMD_SGE:  flag = $signed(a) >= $signed(b);
			default:  ;
		endcase
		// multiply: x is the multiplier, y the multiplicand
		if (cmd == CMD_MUL) begin
			x_n = b;
			y_n = a;
		end else if (is_signed) begin
			x_n = abs_a;
			y_n = abs_b;
		end else begin
			x_n = a;
			y_n = b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= valid;
			ctl_s1.cmd   <= cmd;
			ctl_s1.neg_a <= sa;
			ctl_s1.neg_b <= sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1         <= x_n;
			y_s1         <= y_n;
			r_s1         <= '0;
			simple_s1    <= simple;
			flag_s1      <= flag;
		end
	end

endmodule

### hw/rtl/bva_cell.sv
// One cell of the chain: a restoring divide step or a shift-add multiply
// step, then registers toward the next cell. Depends on bva_pkg.
module bva_cell import bva_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl_i,
	input  logic [WIDTH-1:0] x_i,
	input  logic [WIDTH-1:0] y_i,
	input  logic [WIDTH-1:0] r_i,
	input  logic [WIDTH-1:0] simple_i,
	input  logic             flag_i,
	output ctl_t             ctl_q,
	output logic [WIDTH-1:0] x_q,
	output logic [WIDTH-1:0] y_q,
	output logic [WIDTH-1:0] r_q,
	output logic [WIDTH-1:0] simple_q,
	output logic             flag_q
);

	logic [WIDTH:0]   rs, diff;
	logic             ge;
	logic [WIDTH-1:0] x_n, y_n, r_n;

	always_comb begin
		rs   = {r_i, x_i[WIDTH-1]};
		diff = rs - {1'b0, y_i};
		ge   = !diff[WIDTH];
		if (ctl_i.cmd == CMD_MUL) begin
			r_n = r_i + (x_i[0] ? y_i : '0);
			y_n = y_i << 1;
			x_n = x_i >> 1;
		end else begin
			r_n = ge ? diff[WIDTH-1:0] : rs[WIDTH-1:0];
			y_n = y_i;
			x_n = WIDTH'({x_i, ge});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q         <= x_n;
			y_q         <= y_n;
			r_q         <= r_n;
			simple_q    <= simple_i;
			flag_q      <= flag_i;
		end
	end

endmodule

### hw/rtl/bva_back.sv
// Output stage: sign fix-up of quotient and remainder, result select and
// the output register. Depends on bva_pkg.
module bva_back import bva_pkg::*; #(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  ctl_t              ctl_i,
	input  logic [WIDTH-1:0]  x_i,
	input  logic [WIDTH-1:0]  y_i,
	input  logic [WIDTH-1:0]  r_i,
	input  logic [WIDTH-1:0]  simple_i,
	input  logic              flag_i,
	output logic              valid_q,
	output logic [OPND_W-1:0] value_q,
	output logic              flag_q
);

	logic [WIDTH-1:0] val;

	always_comb begin
		case (ctl_i.cmd) inside
			CMD_MUL, CMD_UREM: val = r_i;
			CMD_UDIV:          val = x_i;
			CMD_SDIV:          val = (ctl_i.neg_a ^ ctl_i.neg_b) ? -x_i : x_i;
			CMD_SREM:          val = ctl_i.neg_a ? -r_i : r_i;
			CMD_SMOD: begin
				// y holds |b|; fold the remainder onto the sign of b
				if (r_i == '0)
					val = '0;
				else if (ctl_i.neg_a && ctl_i.neg_b)
					val = -r_i;
				else if (ctl_i.neg_a)
					val = y_i - r_i;
				else if (ctl_i.neg_b)
					val = r_i - y_i;
				else
					val = r_i;
			end
			default:           val = simple_i;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= OPND_W'(val);
			flag_q  <= flag_i;
		end
	end

endmodule
